// ===== rtl/core/prfll_pkg.sv =====
// ----------------------------------------------------------------------------
// prfll_pkg
// shared types and constants of the page replacement block
// ----------------------------------------------------------------------------
package prfll_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int POOL_DEPTH  = 64;
  localparam int FRAME_BITS  = 12;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PIDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
  localparam int TS_W        = 31;
  localparam int REFS_W      = 16;
  localparam int FAULT_W     = 32;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_POOL     = 3'd1,
    ST_REPLACE  = 3'd2,
    ST_ERROR    = 3'd3,
    ST_PUSHED   = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_LRU  = 2'd1,
    POL_LFU  = 2'd2,
    POL_ALT  = 2'd3
  } policy_t;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_PAGES  = 1'b1;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_PUSH   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_SCAN_LAST,
    S_EVICT,
    S_DONE
  } fsm_t;

endpackage

// ===== rtl/core/prfll_req_if.sv =====
// ----------------------------------------------------------------------------
// prfll_req_if
// request channel into the page replacement block
// ----------------------------------------------------------------------------
interface prfll_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  page;
  logic [30:0] timestamp;
  logic [11:0] frame_in;
  modport source (output valid, cmd, page, timestamp, frame_in, input ready);
  modport sink   (input valid, cmd, page, timestamp, frame_in, output ready);
endinterface

// ===== rtl/core/prfll_rsp_if.sv =====
// ----------------------------------------------------------------------------
// prfll_rsp_if
// result channel out of the page replacement block
// ----------------------------------------------------------------------------
interface prfll_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] frame_out;
  logic [5:0]  victim_page;
  logic [31:0] fault_total;
  modport source (output valid, status, frame_out, victim_page, fault_total, input ready);
  modport sink   (input valid, status, frame_out, victim_page, fault_total, output ready);
endinterface

// ===== rtl/core/prfll_cfg_if.sv =====
// ----------------------------------------------------------------------------
// prfll_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface prfll_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/page_replacement_fifo_lru_lfu.sv =====
// flow: push ends in S_LOOKUP; hit or pool fault goes on to S_DONE; a
//   replacement scans active pages (clamped to table depth) one entry a cycle
//   over the table memory (one read port), then S_SCAN_LAST, S_EVICT, S_DONE
// throughput: one request at a time, next request taken once the result leaves
// reset: synchronous active-low rst_n clears valid bits, pool count, fault
//   count and config; memories hold no reset and need no clearing pass
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_lfu
// page table with free frame pool and fifo/lru/lfu victim selection
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru_lfu
  import prfll_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  prfll_req_if.sink   in_ch,
  prfll_rsp_if.source out_ch,
  prfll_cfg_if.sink   cfg_ch
);

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic [TS_W-1:0]       arrival;
    logic [TS_W-1:0]       last;
    logic [REFS_W-1:0]     refs;
  } entry_t;

  // memories
  entry_t                tbl_mem [TABLE_DEPTH];
  logic [FRAME_BITS-1:0] pool_mem [POOL_DEPTH];
  entry_t                tbl_rd_r;
  logic [FRAME_BITS-1:0] pool_rd_r;

  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PIDX_W-1:0]  head_r, head_nxt;
  logic [FAULT_W-1:0] faults_r, faults_nxt;
  policy_t            policy_r;
  logic [6:0]         pages_r;
  fsm_t               state_r, state_nxt;

  logic                 cmd_r;
  logic [IDX_W-1:0]     page_r;
  logic [TS_W-1:0]      ts_r;
  logic [FRAME_BITS-1:0] fin_r;

  // scan state
  logic [IDX_W:0]    scan_r, scan_nxt;   // address issued
  logic [IDX_W-1:0]  cand_r, cand_nxt;   // index of data in tbl_rd_r
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  best_r, best_nxt;
  logic [TS_W-1:0]   key_r, key_nxt;
  logic [TS_W-1:0]   tie_r, tie_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           ost_r, ost_nxt;
  logic [FRAME_BITS-1:0] ofr_r, ofr_nxt;
  logic [IDX_W-1:0]  ovp_r, ovp_nxt;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              pw_en;
  logic [PIDX_W-1:0] pw_addr;

  logic [6:0]        active;
  logic              cand_ok;
  logic [TS_W-1:0]   ck, ct;
  logic              better;

  assign active = (pages_r > 7'(TABLE_DEPTH)) ? 7'(TABLE_DEPTH) : pages_r;
  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = ost_r;
  assign out_ch.frame_out   = ofr_r;
  assign out_ch.victim_page = ovp_r;
  assign out_ch.fault_total = faults_r;

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) tbl_mem[wr_addr] <= wr_data;
    if (rd_en) tbl_rd_r <= tbl_mem[rd_addr];
  end

  // pool memory, circular
  always_ff @(posedge clk) begin
    if (pw_en) pool_mem[pw_addr] <= fin_r;
    pool_rd_r <= pool_mem[head_r];
  end

  // candidate key for the scan
  always_comb begin
    cand_ok = valid_r[cand_r];
    case (policy_r)
      POL_FIFO: begin ck = tbl_rd_r.arrival; ct = '0; end
      POL_LRU:  begin ck = tbl_rd_r.last;    ct = '0; end
      default:  begin ck = TS_W'(tbl_rd_r.refs); ct = tbl_rd_r.arrival; end
    endcase
    better = cand_ok && (!found_r || ck < key_r || (ck == key_r && ct < tie_r));
  end

  // control
  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    cnt_nxt = cnt_r;
    head_nxt = head_r;
    faults_nxt = faults_r;
    scan_nxt = scan_r;
    cand_nxt = cand_r;
    found_nxt = found_r;
    best_nxt = best_r;
    key_nxt = key_r;
    tie_nxt = tie_r;
    out_valid_nxt = out_valid_r;
    ost_nxt = ost_r;
    ofr_nxt = ofr_r;
    ovp_nxt = ovp_r;
    rd_en = 1'b0;
    rd_addr = page_r;
    wr_en = 1'b0;
    wr_addr = page_r;
    wr_data = tbl_rd_r;
    pw_en = 1'b0;
    pw_addr = PIDX_W'((32'(head_r) + 32'(cnt_r)) % POOL_DEPTH);
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        ofr_nxt = '0;
        ovp_nxt = '0;
        state_nxt = S_DONE;
        if (cmd_r == CMD_PUSH) begin
          if (cnt_r < CNT_W'(POOL_DEPTH)) begin
            pw_en = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            ost_nxt = ST_PUSHED;
          end else begin
            ost_nxt = ST_FULL;
          end
          state_nxt = S_IDLE;
          out_valid_nxt = 1'b1;
        end else if (7'(page_r) >= active) begin
          ost_nxt = ST_ERROR;
          state_nxt = S_IDLE;
          out_valid_nxt = 1'b1;
        end else if (valid_r[page_r]) begin
          rd_en = 1'b1;
          ost_nxt = ST_HIT;
        end else if (cnt_r != '0) begin
          // take oldest pool frame; it is installed in S_DONE
          ost_nxt = ST_POOL;
          cnt_nxt = cnt_r - 1'b1;
          head_nxt = PIDX_W'((32'(head_r) + 1) % POOL_DEPTH);
        end else begin
          rd_en = 1'b1;
          rd_addr = '0;
          scan_nxt = (IDX_W+1)'(1);
          cand_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (better) begin
          found_nxt = 1'b1;
          best_nxt = cand_r;
          key_nxt = ck;
          tie_nxt = ct;
        end
        if (7'(scan_r) < active) begin
          rd_en = 1'b1;
          rd_addr = scan_r[IDX_W-1:0];
          cand_nxt = scan_r[IDX_W-1:0];
          scan_nxt = scan_r + 1'b1;
        end else begin
          state_nxt = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        if (!found_r) begin
          ost_nxt = ST_ERROR;
          state_nxt = S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          rd_en = 1'b1;
          rd_addr = best_r;
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        valid_nxt[best_r] = 1'b0;
        ofr_nxt = tbl_rd_r.frame;
        ovp_nxt = best_r;
        ost_nxt = ST_REPLACE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // write the entry back
        wr_en = 1'b1;
        valid_nxt[page_r] = 1'b1;
        if (ost_r == ST_HIT) begin
          wr_data = tbl_rd_r;
          wr_data.last = ts_r;
          if (tbl_rd_r.refs != '1) wr_data.refs = tbl_rd_r.refs + 1'b1;
          ofr_nxt = tbl_rd_r.frame;
        end else begin
          wr_data.frame = (ost_r == ST_POOL) ? pool_rd_r : ofr_r;
          wr_data.arrival = ts_r;
          wr_data.last = ts_r;
          wr_data.refs = REFS_W'(1);
          ofr_nxt = wr_data.frame;
          if (faults_r != '1) faults_nxt = faults_r + 1'b1;
        end
        state_nxt = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      cnt_r <= '0;
      head_r <= '0;
      faults_r <= '0;
      out_valid_r <= 1'b0;
      policy_r <= POL_FIFO;
      pages_r <= 7'd64;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cnt_r <= cnt_nxt;
      head_r <= head_nxt;
      faults_r <= faults_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_POLICY) policy_r <= policy_t'(cfg_ch.data[1:0]);
        else pages_r <= cfg_ch.data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r <= in_ch.cmd;
      page_r <= in_ch.page;
      ts_r <= in_ch.timestamp;
      fin_r <= in_ch.frame_in;
    end
    scan_r <= scan_nxt;
    cand_r <= cand_nxt;
    found_r <= found_nxt;
    best_r <= best_nxt;
    key_r <= key_nxt;
    tie_r <= tie_nxt;
    ost_r <= ost_nxt;
    ofr_r <= ofr_nxt;
    ovp_r <= ovp_nxt;
  end

`ifndef SYNTHESIS
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(POOL_DEPTH)) else $error("pool count overflow");
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE) else $error("result pending while busy");
  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    faults_r >= $past(faults_r)) else $error("fault count decreased");
  a_install_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> valid_r[$past(page_r)]) else $error("entry not installed");
`endif

endmodule

// ===== verif/page_replacement_fifo_lru_lfu_tb.sv =====
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_lfu_tb
// Self-checking bench for the page table / free frame pool block. A short
// directed table walks the extremes, every status but full and every
// replacement policy. Random phases at several policy and page-count
// settings follow, with random idling on both channels. Each result is
// checked against a fixed expectation or a page table and pool predictor.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru_lfu_tb;
  import prfll_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_WAIT  = 80;
  localparam int PHASE_ITEMS = 170;

  typedef struct packed {
    status_t     status;
    logic [11:0] frame;
    logic [5:0]  victim;
    logic [31:0] faults;
  } page_rsp_t;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        cmd;
    logic [5:0]  page;
    logic [30:0] ts;
    logic [11:0] frame;
    logic        reg_idx;
    logic [6:0]  reg_val;
    logic        has_exp;
    page_rsp_t   exp;
  } stim_row_t;

  logic clk;
  logic rst_n;

  prfll_req_if in_ch ();
  prfll_rsp_if out_ch ();
  prfll_cfg_if cfg_ch ();

  page_replacement_fifo_lru_lfu dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  policy_t     cur_policy;
  logic [6:0]  cur_pages;
  logic        pt_valid   [TABLE_DEPTH];
  logic [11:0] pt_frame   [TABLE_DEPTH];
  logic [30:0] pt_arrival [TABLE_DEPTH];
  logic [30:0] pt_last    [TABLE_DEPTH];
  logic [15:0] pt_refs    [TABLE_DEPTH];
  logic [11:0] free_pool  [$];
  logic [31:0] fault_cnt;

  page_rsp_t   pending_rsp [$];
  stim_row_t   directed    [$];
  int          err_count;
  int          cycle_cnt;
  int          stall_left;
  int          ready_roll;
  logic        calm;
  logic [30:0] ts_now;

  // clock and cycle guard
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // predicted outcome of one request, updates the shadow table and pool
  function automatic page_rsp_t page_table_step(logic cmd, logic [5:0] page,
                                                logic [30:0] ts, logic [11:0] fr);
    page_rsp_t   r;
    int          n;
    int          best;
    logic        found;
    logic [31:0] k, t, key, tie;
    r = '{status: ST_ERROR, frame: '0, victim: '0, faults: '0};
    n = (cur_pages > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_pages);
    found = 1'b0;
    best = 0;
    key = '0;
    tie = '0;
    if (cmd == CMD_PUSH) begin
      if (free_pool.size() < POOL_DEPTH) begin
        free_pool.push_back(fr);
        r.status = ST_PUSHED;
      end else begin
        r.status = ST_FULL;
      end
    end else if (int'(page) >= n) begin
      r.status = ST_ERROR;
    end else if (pt_valid[page]) begin
      pt_last[page] = ts;
      if (pt_refs[page] != 16'hffff) pt_refs[page] = pt_refs[page] + 16'd1;
      r.frame = pt_frame[page];
      r.status = ST_HIT;
    end else if (free_pool.size() > 0) begin
      r.frame = free_pool.pop_front();
      r.status = ST_POOL;
    end else begin
      // victim scan, lowest index wins ties
      for (int i = 0; i < n; i++) begin
        if (!pt_valid[i]) continue;
        if (cur_policy == POL_FIFO) begin
          k = 32'(pt_arrival[i]);
          t = '0;
        end else if (cur_policy == POL_LRU) begin
          k = 32'(pt_last[i]);
          t = '0;
        end else begin
          k = 32'(pt_refs[i]);
          t = 32'(pt_arrival[i]);
        end
        if (!found || k < key || (k == key && t < tie)) begin
          found = 1'b1;
          best = i;
          key = k;
          tie = t;
        end
      end
      if (found) begin
        r.frame = pt_frame[best];
        r.victim = best[5:0];
        pt_valid[best] = 1'b0;
        r.status = ST_REPLACE;
      end
    end
    // install the faulting page
    if (r.status == ST_POOL || r.status == ST_REPLACE) begin
      pt_valid[page] = 1'b1;
      pt_frame[page] = r.frame;
      pt_arrival[page] = ts;
      pt_last[page] = ts;
      pt_refs[page] = 16'd1;
      if (fault_cnt != 32'hffff_ffff) fault_cnt = fault_cnt + 32'd1;
    end
    r.faults = fault_cnt;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request on the input channel; valid stays up when no gap follows
  task automatic send_request(logic cmd, logic [5:0] page, logic [30:0] ts,
                              logic [11:0] fr, logic has_exp, page_rsp_t exp);
    page_rsp_t pred;
    int        gap;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.page <= page;
    in_ch.timestamp <= ts;
    in_ch.frame_in <= fr;
    do @(posedge clk); while (!in_ch.ready);
    pred = page_table_step(cmd, page, ts, fr);
    pending_rsp.push_back(has_exp ? exp : pred);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let every request drain before touching registers
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_POLICY) cur_policy = policy_t'(val[1:0]);
    else cur_pages = val;
  endtask

  function automatic void add_req(logic cmd, logic [5:0] page, logic [30:0] ts,
                                  logic [11:0] fr);
    directed.push_back('{ROW_REQ, cmd, page, ts, fr, 1'b0, 7'd0, 1'b0, '0});
  endfunction

  function automatic void add_chk(logic cmd, logic [5:0] page, logic [30:0] ts,
                                  logic [11:0] fr, page_rsp_t exp);
    directed.push_back('{ROW_REQ, cmd, page, ts, fr, 1'b0, 7'd0, 1'b1, exp});
  endfunction

  function automatic void add_cfg(logic idx, logic [6:0] val);
    directed.push_back('{ROW_CFG, 1'b0, 6'd0, 31'd0, 12'd0, idx, val, 1'b0, '0});
  endfunction

  // result side: random backpressure with occasional long stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (!calm && ready_roll < 3) stall_left <= $urandom_range(10, 40);
      out_ch.ready <= calm || ready_roll >= 20;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no request outstanding: status %0d", out_ch.status);
        err_count++;
      end else begin
        automatic page_rsp_t e = pending_rsp.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          err_count++;
        end
        if (out_ch.frame_out !== e.frame) begin
          $error("frame_out: expected %0h, got %0h", e.frame, out_ch.frame_out);
          err_count++;
        end
        if (out_ch.victim_page !== e.victim) begin
          $error("victim_page: expected %0d, got %0d", e.victim, out_ch.victim_page);
          err_count++;
        end
        if (out_ch.fault_total !== e.faults) begin
          $error("fault_total: expected %0d, got %0d", e.faults, out_ch.fault_total);
          err_count++;
        end
      end
    end
  end

  initial begin
    int        pol_set   [10];
    int        pages_set [10];
    int        roll;
    logic [5:0] pg;
    logic [30:0] ts;

    clk = 1'b0;
    rst_n = 1'b0;
    calm = 1'b0;
    cycle_cnt = 0;
    err_count = 0;
    ts_now = 31'd100;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ACCESS;
    in_ch.page = '0;
    in_ch.timestamp = '0;
    in_ch.frame_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_POLICY;
    cfg_ch.data = '0;
    cur_policy = POL_FIFO;
    cur_pages = 7'd64;
    fault_cnt = '0;
    foreach (pt_valid[i]) pt_valid[i] = 1'b0;

    // directed table: empty table, pool extremes, each policy, range errors
    add_chk(CMD_ACCESS, 6'd0, 31'd10, 12'd0, '{ST_ERROR, 12'h000, 6'd0, 32'd0});
    add_chk(CMD_PUSH, 6'd0, 31'd0, 12'hfff, '{ST_PUSHED, 12'h000, 6'd0, 32'd0});
    add_chk(CMD_PUSH, 6'd63, 31'h7fffffff, 12'h000,
            '{ST_PUSHED, 12'h000, 6'd0, 32'd0});
    add_chk(CMD_ACCESS, 6'd63, 31'h7ffffffe, 12'd0,
            '{ST_POOL, 12'hfff, 6'd0, 32'd1});
    add_chk(CMD_ACCESS, 6'd63, 31'd20, 12'd0, '{ST_HIT, 12'hfff, 6'd0, 32'd1});
    add_chk(CMD_ACCESS, 6'd0, 31'd0, 12'd0, '{ST_POOL, 12'h000, 6'd0, 32'd2});
    add_chk(CMD_ACCESS, 6'd5, 31'd30, 12'd0, '{ST_REPLACE, 12'h000, 6'd0, 32'd3});
    add_cfg(CFG_POLICY, 7'(POL_LRU));
    add_req(CMD_ACCESS, 6'd5, 31'd40, 12'd0);
    add_req(CMD_ACCESS, 6'd63, 31'd50, 12'd0);
    add_req(CMD_ACCESS, 6'd1, 31'd60, 12'd0);
    add_cfg(CFG_POLICY, 7'(POL_LFU));
    add_req(CMD_ACCESS, 6'd1, 31'd65, 12'd0);
    add_req(CMD_ACCESS, 6'd2, 31'h7fffffff, 12'd0);
    add_req(CMD_ACCESS, 6'd4, 31'd70, 12'd0);
    add_cfg(CFG_POLICY, 7'(POL_ALT));
    add_req(CMD_ACCESS, 6'd3, 31'd80, 12'd0);
    add_cfg(CFG_PAGES, 7'd1);
    add_req(CMD_ACCESS, 6'd63, 31'd90, 12'd0);
    add_req(CMD_ACCESS, 6'd0, 31'd95, 12'd0);
    add_cfg(CFG_PAGES, 7'd64);
    add_cfg(CFG_POLICY, 7'(POL_FIFO));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG)
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      else
        send_request(directed[i].cmd, directed[i].page, directed[i].ts,
                     directed[i].frame, directed[i].has_exp, directed[i].exp);
    end

    // random phases over policy and page-count settings
    pol_set   = '{POL_FIFO, POL_LRU, POL_LFU, POL_ALT, POL_LRU,
                  POL_FIFO, POL_LFU, POL_LRU, POL_LFU, POL_FIFO};
    pages_set = '{64, 8, 16, 64, 1, 33, 64, 2, 4, 12};
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_POLICY, 7'(pol_set[ph]));
      write_reg(CFG_PAGES, 7'(pages_set[ph]));
      calm = (ph == 3 || ph == 7);
      // fill the pool past its depth on some phases
      if (ph == 2 || ph == 6) begin
        for (int j = 0; j < POOL_DEPTH + 3; j++)
          send_request(CMD_PUSH, 6'd0, 31'd0, 12'($urandom), 1'b0, '0);
      end
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        roll = $urandom_range(0, 99);
        ts_now = ts_now + 31'($urandom_range(0, 3));
        ts = ts_now;
        if ($urandom_range(0, 19) == 0)
          ts = ($urandom_range(0, 3) == 0) ? 31'h7fffffff : 31'($urandom);
        if (roll < 10) pg = 6'($urandom);
        else pg = 6'($urandom_range(0, pages_set[ph] - 1));
        if (roll >= 10 && roll < 28)
          send_request(CMD_PUSH, 6'($urandom), 31'($urandom), 12'($urandom),
                       1'b0, '0);
        else
          send_request(CMD_ACCESS, pg, ts, 12'($urandom), 1'b0, '0);
      end
    end
    calm = 1'b0;

    wait_idle();
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
